// ----- rtl/core/pcf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes of the packet chunk fragmenter.
package pcf_pkg;

  localparam int HEADER_BYTES = 7;
  localparam int MAX_OUT_MTU  = 512;
  localparam int MAX_IN_LEN   = 65535;
  localparam int MAX_RESULTS  = 64;
  localparam int CNT_W        = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // item mode codes
  localparam logic [1:0] MODE_PACKET = 2'd0;
  localparam logic [1:0] MODE_BUFFER = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_CANCEL = 2'd3;

  // command codes passed to the back end
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_BUFFER = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_BUF_SIZE      = 2'd0;
  localparam logic [1:0] REG_CHUNK_LIMIT   = 2'd1;
  localparam logic [1:0] REG_FLUSH_MODE    = 2'd2;
  localparam logic [1:0] REG_LATENCY_TICKS = 2'd3;

  localparam logic [9:0]  RST_BUF_SIZE      = 10'd512;
  localparam logic [15:0] RST_CHUNK_LIMIT   = 16'd0;
  localparam logic        RST_FLUSH_MODE    = 1'b1;
  localparam logic [15:0] RST_LATENCY_TICKS = 16'd0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] packet_len;
  } item_t;

  typedef struct packed {
    logic        has_chunk;
    logic [15:0] frame_number;
    logic [15:0] chunk_pos;
    logic [15:0] chunk_bytes;
    logic        chunk_is_last;
    logic [8:0]  chunk_offset;
    logic        input_done;
    logic        output_done;
    logic [9:0]  output_len;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  buf_size;
    logic [15:0] chunk_limit;
    logic        flush_mode;
    logic [15:0] latency_ticks;
  } cfg_t;

endpackage

// ----- rtl/core/pcf_front.sv -----
`timescale 1ns / 1ps
// Front end: takes item beats and turns them into queued commands.
module pcf_front (
  input  logic           item_valid,
  output logic           item_stall,
  input  pcf_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output pcf_pkg::cmd_t  q_cmd
);
  import pcf_pkg::*;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_cmd.len = item.packet_len;
    // saturate to the largest packet the back end tracks
    if (17'(item.packet_len) > 17'(MAX_IN_LEN)) begin
      q_cmd.len = 16'(MAX_IN_LEN);
    end
    case (item.mode)
      MODE_PACKET: q_cmd.op = OP_PACKET;
      MODE_BUFFER: q_cmd.op = OP_BUFFER;
      MODE_TICK:   q_cmd.op = OP_TICK;
      MODE_CANCEL: q_cmd.op = OP_CANCEL;
      default:     q_cmd.op = OP_CANCEL;
    endcase
  end

endmodule

// ----- rtl/core/pcf_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between front and back end.
module pcf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output pcf_pkg::cmd_t head
);
  import pcf_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pcf_back.sv -----
`timescale 1ns / 1ps
// Back end: fragmenter state, chunk loop and output register.
module pcf_back (
  input  logic             clk,
  input  logic             rst,
  input  pcf_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  input  pcf_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output pcf_pkg::result_t result
);
  import pcf_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_WRITE = 1'b1;

  logic        state, state_next;
  logic        input_pending, input_pending_next;
  logic [15:0] input_length, input_length_next;
  logic [15:0] input_consumed, input_consumed_next;
  logic        output_held, output_held_next;
  logic [9:0]  output_fill, output_fill_next;
  logic [15:0] frame_counter, frame_counter_next;
  logic        timer_running, timer_running_next;
  logic [15:0] timer_count, timer_count_next;
  logic [CNT_W-1:0] chunk_cnt, chunk_cnt_next;

  logic    slot_free;
  logic    emit;
  result_t emit_data;

  // chunk step datapath
  logic [9:0]  mtu_eff;
  logic [11:0] room, room_n;
  logic        room_pos, room_n_pos;
  logic [15:0] left, left_n;
  logic [9:0]  c_fit, c_len;
  logic [9:0]  fill_n;
  logic        in_done, finish, last_step;

  assign slot_free = !result_valid || !result_stall;

  always_comb begin
    mtu_eff = (cfg.buf_size > 10'(MAX_OUT_MTU)) ? 10'(MAX_OUT_MTU) : cfg.buf_size;
    room     = {2'b00, mtu_eff} - {2'b00, output_fill} - 12'(HEADER_BYTES);
    room_pos = !room[11] && (room != '0);
    left     = input_length - input_consumed;
    c_fit    = (left < {6'b0, room[9:0]}) ? left[9:0] : room[9:0];
    c_len    = c_fit;
    if ((cfg.chunk_limit != '0) && (cfg.chunk_limit < {6'b0, c_fit})) begin
      c_len = cfg.chunk_limit[9:0];
    end
    fill_n     = output_fill + 10'(HEADER_BYTES) + c_len;
    left_n     = left - {6'b0, c_len};
    room_n     = {2'b00, mtu_eff} - {2'b00, fill_n} - 12'(HEADER_BYTES);
    room_n_pos = !room_n[11] && (room_n != '0);
    in_done    = (left_n == '0);
    last_step  = !(left_n != '0 && room_n_pos && chunk_cnt != CNT_W'(MAX_RESULTS - 1));
    // result cap reached with input left counts as a full buffer
    finish     = !room_n_pos || !cfg.flush_mode ||
                 (chunk_cnt == CNT_W'(MAX_RESULTS - 1) && !in_done);
  end

  always_comb begin
    state_next          = state;
    input_pending_next  = input_pending;
    input_length_next   = input_length;
    input_consumed_next = input_consumed;
    output_held_next    = output_held;
    output_fill_next    = output_fill;
    frame_counter_next  = frame_counter;
    timer_running_next  = timer_running;
    timer_count_next    = timer_count;
    chunk_cnt_next      = chunk_cnt;
    cmd_pop             = 1'b0;
    emit                = 1'b0;
    emit_data           = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PACKET: begin
              if (!input_pending) begin
                input_pending_next  = 1'b1;
                input_length_next   = cmd.len;
                input_consumed_next = '0;
                if (output_held) begin
                  state_next     = S_WRITE;
                  chunk_cnt_next = '0;
                end
              end
            end
            OP_BUFFER: begin
              if (!output_held) begin
                output_held_next = 1'b1;
                output_fill_next = '0;
                if (input_pending) begin
                  state_next     = S_WRITE;
                  chunk_cnt_next = '0;
                end
              end
            end
            OP_TICK: begin
              if (timer_running) begin
                if (timer_count < cfg.latency_ticks) begin
                  timer_count_next = timer_count + 1'b1;
                end else begin
                  timer_running_next = 1'b0;
                  timer_count_next   = '0;
                  if (output_held) begin
                    output_held_next      = 1'b0;
                    emit                  = 1'b1;
                    emit_data.output_done = 1'b1;
                    emit_data.output_len  = output_fill;
                    emit_data.last        = 1'b1;
                  end
                end
              end
            end
            OP_CANCEL: begin
              if (input_pending && !output_held) begin
                input_pending_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!room_pos) begin
            // no room for header plus a byte: release buffer, input stays
            emit_data.output_done = 1'b1;
            emit_data.output_len  = output_fill;
            emit_data.last        = 1'b1;
            output_held_next      = 1'b0;
            timer_running_next    = 1'b0;
            timer_count_next      = '0;
            state_next            = S_IDLE;
          end else begin
            emit_data.has_chunk     = 1'b1;
            emit_data.frame_number  = frame_counter;
            emit_data.chunk_pos     = input_consumed;
            emit_data.chunk_bytes   = {6'b0, c_len};
            emit_data.chunk_is_last = ({6'b0, c_len} == left);
            emit_data.chunk_offset  = output_fill[8:0];
            input_consumed_next     = input_consumed + {6'b0, c_len};
            output_fill_next        = fill_n;
            chunk_cnt_next          = chunk_cnt + 1'b1;
            if (last_step) begin
              emit_data.last = 1'b1;
              state_next     = S_IDLE;
              if (in_done) begin
                emit_data.input_done = 1'b1;
                input_pending_next   = 1'b0;
                frame_counter_next   = frame_counter + 1'b1;
              end
              if (finish) begin
                emit_data.output_done = 1'b1;
                emit_data.output_len  = fill_n;
                output_held_next      = 1'b0;
                timer_running_next    = 1'b0;
                timer_count_next      = '0;
              end else if (!timer_running) begin
                timer_running_next = 1'b1;
                timer_count_next   = '0;
              end
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      input_pending  <= 1'b0;
      input_length   <= '0;
      input_consumed <= '0;
      output_held    <= 1'b0;
      output_fill    <= '0;
      frame_counter  <= '0;
      timer_running  <= 1'b0;
      timer_count    <= '0;
      chunk_cnt      <= '0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      input_pending  <= input_pending_next;
      input_length   <= input_length_next;
      input_consumed <= input_consumed_next;
      output_held    <= output_held_next;
      output_fill    <= output_fill_next;
      frame_counter  <= frame_counter_next;
      timer_running  <= timer_running_next;
      timer_count    <= timer_count_next;
      chunk_cnt      <= chunk_cnt_next;
      if (slot_free) begin
        result_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      result <= emit_data;
    end
  end

  a_write_needs_both: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (input_pending && output_held))
    else $error("chunk loop running without input and buffer");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    output_fill <= 10'(MAX_OUT_MTU))
    else $error("output fill beyond buffer size");

  a_consumed_bound: assert property (@(posedge clk) disable iff (rst)
    input_consumed <= input_length)
    else $error("consumed more than packet length");

  a_bare_is_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.has_chunk) |-> (result.last && result.output_done))
    else $error("chunkless beat that does not close the buffer");

endmodule

// ----- rtl/core/packet_chunk_fragmenter.sv -----
`timescale 1ns / 1ps
// Top level of the packet chunk fragmenter: register port, front, queue, back.
//
//   port group | dir | beat / access         | flow control
//   -----------+-----+-----------------------+----------------------------
//   item       | in  | item_t (mode, length) | item_valid / item_stall
//   result     | out | result_t descriptor   | result_valid / result_stall
//   apb        | in  | 4 x 32-bit registers  | pready tied high
//
// An item enters the 4-deep command queue in its accept cycle. The back end
// takes one command per cycle when idle and not stalled; packet and buffer
// events that start a write then hold it for up to 64 chunk descriptor beats.
// Reset is synchronous; registers return to their defaults, no clearing pass.
// result_stall holds the output register and the back end behind it; once the
// queue is full, item_stall rises.
module packet_chunk_fragmenter (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pcf_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output pcf_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pcf_pkg::*;

  cfg_t cfg;
  logic cfg_wr;

  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t q_in, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buf_size      <= RST_BUF_SIZE;
      cfg.chunk_limit   <= RST_CHUNK_LIMIT;
      cfg.flush_mode    <= RST_FLUSH_MODE;
      cfg.latency_ticks <= RST_LATENCY_TICKS;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BUF_SIZE:      cfg.buf_size      <= pwdata[9:0];
        REG_CHUNK_LIMIT:   cfg.chunk_limit   <= pwdata[15:0];
        REG_FLUSH_MODE:    cfg.flush_mode    <= pwdata[0];
        REG_LATENCY_TICKS: cfg.latency_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BUF_SIZE:      prdata = {22'b0, cfg.buf_size};
      REG_CHUNK_LIMIT:   prdata = {16'b0, cfg.chunk_limit};
      REG_FLUSH_MODE:    prdata = {31'b0, cfg.flush_mode};
      REG_LATENCY_TICKS: prdata = {16'b0, cfg.latency_ticks};
      default:           prdata = '0;
    endcase
  end

  pcf_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  pcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (q_not_empty),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
